// ===== hw/rtl/stbm_pkg.sv =====
package stbm_pkg;

	localparam int MAX_STAGES = 16;
	localparam int TIME_BITS  = 24;

	// Field widths fixed by the stream format
	localparam int CMD_BITS    = 2;
	localparam int IDX_BITS    = 4;
	localparam int CNT_BITS    = 5;
	localparam int SPREAD_BITS = 16;
	localparam int THR_BITS    = 16;

	localparam int LOG_STAGES = $clog2(MAX_STAGES);
	localparam int SUM_BITS   = TIME_BITS + LOG_STAGES;
	localparam int SQ_BITS    = 2 * TIME_BITS;
	localparam int SQS_BITS   = 2 * TIME_BITS + LOG_STAGES;
	localparam int D_BITS     = 2 * SUM_BITS;

	// 25600^2 = 625 * 2^20: scale the variance term before the root
	localparam int SCALE_MUL       = 625;
	localparam int SCALE_MUL_BITS  = 10;
	localparam int SCALE_SHIFT     = 20;
	localparam int SCALED_BITS     = D_BITS + SCALE_MUL_BITS;
	localparam int NUM_BITS        = D_BITS + SCALE_MUL_BITS + SCALE_SHIFT;
	localparam int ROOT_BITS       = NUM_BITS / 2;
	localparam int SQREM_BITS      = ROOT_BITS + 2;
	localparam int ITER_BITS       = $clog2(ROOT_BITS);

	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(2560);

	localparam logic [CMD_BITS-1:0] CMD_RECORD = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

	localparam int IN_DATA_BITS  = 32;
	localparam int OUT_DATA_BITS = 88;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_LOAD,
		ST_MUL,
		ST_ACC,
		ST_PROD,
		ST_DIFF,
		ST_SCALE,
		ST_SQRT,
		ST_DIVS_INIT,
		ST_DIVS,
		ST_SPREAD,
		ST_DIVM_INIT,
		ST_DIVM,
		ST_MEAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic load;
		logic mul;
		logic acc;
		logic prod;
		logic diff;
		logic scale;
		logic sqrt_step;
		logic div_spread_init;
		logic div_mean_init;
		logic div_step;
		logic spread_take;
		logic mean_take;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic held_zero;
		logic last_entry;
		logic s1_zero;
		logic out_busy;
	} ctl_sts_t;

endpackage

// ===== hw/rtl/stbm_ctrl.sv =====
module stbm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  stbm_pkg::ctl_sts_t sts,
	output stbm_pkg::ctl_cmd_t cmd
);
	import stbm_pkg::*;

	state_t               state_q, state_d;
	logic [ITER_BITS-1:0] iter_q, iter_d;
	logic                 iter_last;

	assign iter_last = (iter_q == ITER_BITS'(ROOT_BITS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			iter_q  <= '0;
		end else begin
			state_q <= state_d;
			iter_q  <= iter_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		iter_d   = iter_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (sts.held_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.load = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = sts.last_entry ? ST_PROD : ST_LOAD;
			end
			ST_PROD: begin
				cmd.prod = 1'b1;
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				iter_d = '0;
				state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				iter_d = iter_q + 1'b1;
				if (iter_last) begin
					state_d = sts.s1_zero ? ST_DIVM_INIT : ST_DIVS_INIT;
				end
			end
			ST_DIVS_INIT: begin
				cmd.div_spread_init = 1'b1;
				iter_d = '0;
				state_d = ST_DIVS;
			end
			ST_DIVS: begin
				cmd.div_step = 1'b1;
				iter_d = iter_q + 1'b1;
				if (iter_last) begin
					state_d = ST_SPREAD;
				end
			end
			ST_SPREAD: begin
				cmd.spread_take = 1'b1;
				state_d = ST_DIVM_INIT;
			end
			ST_DIVM_INIT: begin
				cmd.div_mean_init = 1'b1;
				iter_d = '0;
				state_d = ST_DIVM;
			end
			ST_DIVM: begin
				cmd.div_step = 1'b1;
				iter_d = iter_q + 1'b1;
				if (iter_last) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN: begin
				cmd.mean_take = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_update_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> $past(state_q == ST_IDLE && in_valid))
		else $error("update without an accepted transaction");

	a_no_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result loaded over a pending result");

	a_empty_skips_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD && sts.held_zero) |=> (state_q == ST_FINISH))
		else $error("empty table did not skip the walk");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT || state_q == ST_DIVS || state_q == ST_DIVM)
		|-> (iter_q <= ITER_BITS'(ROOT_BITS - 1)))
		else $error("iteration count out of range");

endmodule

// ===== hw/rtl/stbm_dp.sv =====
module stbm_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  stbm_pkg::ctl_cmd_t                cmd,
	output stbm_pkg::ctl_sts_t                sts,
	input  logic [stbm_pkg::CMD_BITS-1:0]     in_cmd,
	input  logic [stbm_pkg::IDX_BITS-1:0]     in_idx,
	input  logic [stbm_pkg::TIME_BITS-1:0]    in_time,
	input  logic                              thr_we,
	input  logic [stbm_pkg::THR_BITS-1:0]     thr_wdata,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [stbm_pkg::OUT_DATA_BITS-1:0] out_data
);
	import stbm_pkg::*;

	logic [THR_BITS-1:0]  thr_q;
	logic [CMD_BITS-1:0]  cmd_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [TIME_BITS-1:0] time_q;

	logic [TIME_BITS-1:0] times_q [MAX_STAGES];
	logic [MAX_STAGES-1:0] vld_q;
	logic [CNT_BITS-1:0]  held_q;

	logic [IDX_BITS-1:0]  ent_q;
	logic [TIME_BITS-1:0] x_q, max_q, min_q;
	logic [IDX_BITS-1:0]  slow_q, fast_q;
	logic [SQ_BITS-1:0]   sq_q;
	logic [SUM_BITS-1:0]  s1_q;
	logic [SQS_BITS-1:0]  s2_q;
	logic [D_BITS-1:0]    ns2_q, s1sq_q, d_q;
	logic [NUM_BITS-1:0]  num_q;
	logic [SQREM_BITS-1:0] sqrem_q;
	logic [ROOT_BITS-1:0] root_q;
	logic [SUM_BITS-1:0]  drem_q, den_q;
	logic [ROOT_BITS-1:0] dvd_q;

	logic [SPREAD_BITS-1:0] spread_q;
	logic [TIME_BITS-1:0]   mean_q, read_q;
	logic                   err_q;

	logic                   rec_err;
	logic [TIME_BITS-1:0]   ent_val;
	logic [SQREM_BITS-1:0]  sq_sh, sq_trial;
	logic [SUM_BITS:0]      dv_sh, dv_den;
	logic                   spread_bal;

	assign rec_err = ({1'b0, idx_q} >= CNT_BITS'(MAX_STAGES));
	assign ent_val = vld_q[ent_q] ? times_q[ent_q] : '0;

	assign sq_sh    = {sqrem_q[SQREM_BITS-3:0], num_q[NUM_BITS-1 -: 2]};
	assign sq_trial = {root_q, 2'b01};
	assign dv_sh    = {drem_q, dvd_q[ROOT_BITS-1]};
	assign dv_den   = {1'b0, den_q};

	assign sts.held_zero  = (held_q == '0);
	assign sts.last_entry = ((CNT_BITS'(ent_q) + 1'b1) == held_q);
	assign sts.s1_zero    = (s1_q == '0);
	assign sts.out_busy   = out_valid && !out_ready;

	assign spread_bal = (spread_q < thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (thr_we) begin
			thr_q <= thr_wdata;
		end
	end

	// table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			held_q <= '0;
		end else if (cmd.update) begin
			if (cmd_q == CMD_RECORD && !rec_err) begin
				vld_q[idx_q] <= 1'b1;
				if ((CNT_BITS'(idx_q) + 1'b1) > held_q) begin
					held_q <= CNT_BITS'(idx_q) + 1'b1;
				end
			end else if (cmd_q == CMD_CLEAR) begin
				vld_q  <= '0;
				held_q <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q  <= in_cmd;
			idx_q  <= in_idx;
			time_q <= in_time;
		end
		if (cmd.update) begin
			if (cmd_q == CMD_RECORD && !rec_err) begin
				times_q[idx_q] <= time_q;
			end
			read_q   <= (cmd_q == CMD_READ && vld_q[idx_q]) ? times_q[idx_q] : '0;
			err_q    <= (cmd_q == CMD_RECORD) && rec_err;
			ent_q    <= '0;
			s1_q     <= '0;
			s2_q     <= '0;
			slow_q   <= '0;
			fast_q   <= '0;
			mean_q   <= '0;
			spread_q <= '0;
		end
		if (cmd.load) begin
			x_q  <= ent_val;
			s1_q <= s1_q + SUM_BITS'(ent_val);
			if (ent_q == '0) begin
				max_q <= ent_val;
				min_q <= ent_val;
			end else begin
				if (ent_val > max_q) begin
					max_q  <= ent_val;
					slow_q <= ent_q;
				end
				if (ent_val < min_q) begin
					min_q  <= ent_val;
					fast_q <= ent_q;
				end
			end
		end
		if (cmd.mul) begin
			sq_q <= x_q * x_q;
		end
		if (cmd.acc) begin
			s2_q  <= s2_q + SQS_BITS'(sq_q);
			ent_q <= ent_q + 1'b1;
		end
		if (cmd.prod) begin
			ns2_q  <= D_BITS'(s2_q) * D_BITS'(held_q);
			s1sq_q <= s1_q * s1_q;
		end
		if (cmd.diff) begin
			d_q <= ns2_q - s1sq_q;
		end
		if (cmd.scale) begin
			num_q   <= {SCALED_BITS'(d_q) * SCALED_BITS'(SCALE_MUL), SCALE_SHIFT'(0)};
			sqrem_q <= '0;
			root_q  <= '0;
		end
		if (cmd.sqrt_step) begin
			num_q <= {num_q[NUM_BITS-3:0], 2'b00};
			if (sq_sh >= sq_trial) begin
				sqrem_q <= sq_sh - sq_trial;
				root_q  <= {root_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				sqrem_q <= sq_sh;
				root_q  <= {root_q[ROOT_BITS-2:0], 1'b0};
			end
		end
		if (cmd.div_spread_init) begin
			dvd_q  <= root_q;
			den_q  <= s1_q;
			drem_q <= '0;
		end
		if (cmd.div_mean_init) begin
			dvd_q  <= ROOT_BITS'(s1_q);
			den_q  <= SUM_BITS'(held_q);
			drem_q <= '0;
		end
		if (cmd.div_step) begin
			if (dv_sh >= dv_den) begin
				drem_q <= SUM_BITS'(dv_sh - dv_den);
				dvd_q  <= {dvd_q[ROOT_BITS-2:0], 1'b1};
			end else begin
				drem_q <= dv_sh[SUM_BITS-1:0];
				dvd_q  <= {dvd_q[ROOT_BITS-2:0], 1'b0};
			end
		end
		if (cmd.spread_take) begin
			spread_q <= (|dvd_q[ROOT_BITS-1:SPREAD_BITS]) ? '1 : dvd_q[SPREAD_BITS-1:0];
		end
		if (cmd.mean_take) begin
			mean_q <= dvd_q[TIME_BITS-1:0];
		end
		if (cmd.out_load) begin
			out_data <= {7'b0, err_q, read_q, ((held_q != '0) && !spread_bal),
				fast_q, slow_q, (held_q != '0), spread_bal, spread_q, mean_q, held_q};
		end
	end

endmodule

// ===== hw/rtl/stage_time_balance_monitor.sv =====
// Stage time balance monitor. Each input transaction records a stage time,
// reads one back, or clears the table (tuser selects which); each one returns
// exactly one result transaction with the stage count, truncated mean, the
// spread (standard deviation over mean in 1/256 percent, saturating at 65535),
// the balanced and rebalance flags, the first slowest and fastest stage, the
// read value and the error flag. Each transaction reads, squares and
// accumulates every held stage, then runs the setup, the square root and the
// two divides (the spread divide is skipped when every held time is zero) in
// the bit-serial root and divide units that produce one result bit per cycle;
// an empty table skips the walk, the root and the divides.
// A finished result sits in the output register, so the next input
// transaction is taken while it waits. Write balance_threshold only while
// the block is idle.
module stage_time_balance_monitor (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [3:0] stage_index, [27:4] time_value, rest zero
	input  logic [stbm_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
	// [1:0] cmd
	input  logic [stbm_pkg::CMD_BITS-1:0]       s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [4:0] stage_total, [28:5] mean_time, [44:29] spread_percent,
	// [45] balanced, [46] stats_valid, [50:47] slowest stage index,
	// [54:51] fastest stage index, [55] rebalance, [79:56] read_time, [80] error
	output logic [stbm_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [stbm_pkg::THR_BITS-1:0]       cfg_wdata
);
	import stbm_pkg::*;

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	// sequencer: walk the table, then run the root and the divides
	stbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// table, accumulators, square root unit, shared divide unit, output register
	stbm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_cmd    (s_axis_tuser),
		.in_idx    (s_axis_tdata[IDX_BITS-1:0]),
		.in_time   (s_axis_tdata[IDX_BITS +: TIME_BITS]),
		.thr_we    (cfg_we),
		.thr_wdata (cfg_wdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== verif/stage_time_balance_monitor_tb.sv =====
`timescale 1ns / 100ps

module stage_time_balance_monitor_tb;
	import stbm_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int DRAIN_WAIT  = 300;   // worst item: a full 16-stage walk plus the root and both divides
	localparam int STALL_LIMIT = 6000;  // cycles with no transaction on either side
	localparam int HOLD_CYCLES = 400;
	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

	// One result, most significant field first, so it overlays m_axis_tdata[80:0]
	typedef struct packed {
		logic                   error;
		logic [TIME_BITS-1:0]   read_time;
		logic                   rebalance;
		logic [IDX_BITS-1:0]    fastest;
		logic [IDX_BITS-1:0]    slowest;
		logic                   stats_valid;
		logic                   balanced;
		logic [SPREAD_BITS-1:0] spread;
		logic [TIME_BITS-1:0]   mean;
		logic [CNT_BITS-1:0]    total;
	} stats_t;

	// Stage table shadow plus the queue of results still owed by the block
	class balance_scoreboard;
		logic [TIME_BITS-1:0] times [MAX_STAGES];
		int unsigned          held;
		logic [THR_BITS-1:0]  threshold;
		stats_t               owed [$];
		int                   mismatches;
		int                   checked;
		int                   balanced_seen;
		int                   saturated_seen;

		function new();
			foreach (times[i]) times[i] = '0;
			held = 0;
			threshold = THR_RESET;
			mismatches = 0;
			checked = 0;
			balanced_seen = 0;
			saturated_seen = 0;
		endfunction

		// Integer square root, floor, of a wide value
		function logic [127:0] isqrt(logic [127:0] num);
			logic [127:0] res;
			logic [127:0] bitv;
			res = '0;
			bitv = 128'd1 << 126;
			while (bitv != 0 && bitv > num) bitv = bitv >> 2;
			while (bitv != 0) begin
				if (num >= res + bitv) begin
					num = num - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
				bitv = bitv >> 2;
			end
			return res;
		endfunction

		function void note_input(logic [CMD_BITS-1:0] cmd, logic [IDX_BITS-1:0] idx,
				logic [TIME_BITS-1:0] tval);
			stats_t       r;
			logic [127:0] s1, s2, d, root, q;
			int unsigned  slow, fast;
			r = '0;
			case (cmd)
				CMD_RECORD: begin
					// skipped entries between the old count and idx read as zero
					for (int i = held; i < idx; i++) times[i] = '0;
					times[idx] = tval;
					if (idx + 1 > held) held = idx + 1;
				end
				CMD_READ: begin
					if (idx < held) r.read_time = times[idx];
				end
				CMD_CLEAR: begin
					foreach (times[i]) times[i] = '0;
					held = 0;
				end
				default: ;
			endcase
			s1 = '0;
			s2 = '0;
			slow = 0;
			fast = 0;
			for (int i = 0; i < held; i++) begin
				s1 += times[i];
				s2 += 128'(times[i]) * 128'(times[i]);
				if (times[i] > times[slow]) slow = i;
				if (times[i] < times[fast]) fast = i;
			end
			r.total = CNT_BITS'(held);
			r.stats_valid = held != 0;
			if (held != 0) begin
				r.mean = TIME_BITS'(s1 / held);
				r.slowest = IDX_BITS'(slow);
				r.fastest = IDX_BITS'(fast);
				if (s1 != 0) begin
					d = s2 * held - s1 * s1;
					root = isqrt(d * 128'd655360000);
					q = root / s1;
					r.spread = (q > 65535) ? 16'hFFFF : q[15:0];
				end
			end
			r.balanced = r.spread < threshold;
			r.rebalance = r.stats_valid && !r.balanced;
			owed = {owed, r};
		endfunction

		task report(string what, logic [127:0] got, logic [127:0] want);
			mismatches++;
			$display("mismatch on result %0d: %s got %0h expected %0h", checked, what, got,
				want);
		endtask

		task check_result(logic [OUT_DATA_BITS-1:0] data);
			stats_t a, e;
			a = data[$bits(stats_t)-1:0];
			if (owed.size() == 0) begin
				report("unexpected result", a, 0);
				return;
			end
			e = owed.pop_front();
			if (a.total != e.total) report("stage_total", a.total, e.total);
			if (a.mean != e.mean) report("mean_time", a.mean, e.mean);
			if (a.spread != e.spread) report("spread_percent", a.spread, e.spread);
			if (a.balanced != e.balanced) report("balanced", a.balanced, e.balanced);
			if (a.stats_valid != e.stats_valid) report("stats_valid", a.stats_valid, e.stats_valid);
			if (a.slowest != e.slowest) report("slowest stage", a.slowest, e.slowest);
			if (a.fastest != e.fastest) report("fastest stage", a.fastest, e.fastest);
			if (a.rebalance != e.rebalance) report("rebalance", a.rebalance, e.rebalance);
			if (a.read_time != e.read_time) report("read_time", a.read_time, e.read_time);
			if (a.error != e.error) report("error", a.error, e.error);
			if (e.balanced && e.stats_valid) balanced_seen++;
			if (e.spread == 16'hFFFF) saturated_seen++;
			checked++;
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     s_axis_tvalid;
	logic                     s_axis_tready;
	logic [IN_DATA_BITS-1:0]  s_axis_tdata;
	logic [CMD_BITS-1:0]      s_axis_tuser;
	logic                     m_axis_tvalid;
	logic                     m_axis_tready;
	logic [OUT_DATA_BITS-1:0] m_axis_tdata;
	logic                     cfg_we;
	logic [THR_BITS-1:0]      cfg_wdata;

	balance_scoreboard sb = new();
	bit                idle_off;     // set for the stretch with no idling on either side
	bit                hold_request; // ask the receiver for one long hold-off
	int                sent;
	int                stall_cycles = 0;

	stage_time_balance_monitor dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Receiver: random back-pressure, one long hold-off on request
	initial begin
		bit hold_done;
		hold_done = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_axis_tready <= idle_off || ($urandom_range(0, 99) >= 22);
		end
	end

	// Check every result transaction as it is accepted
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", sb.owed.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Offer one input transaction; hold it until accepted, leave tvalid high
	task send_item(logic [CMD_BITS-1:0] cmd, logic [IDX_BITS-1:0] idx,
			logic [TIME_BITS-1:0] tval);
		while (!idle_off && $urandom_range(0, 99) < 22) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'b0, tval, idx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(cmd, idx, tval);
		sent++;
	endtask

	// Drop tvalid and wait for every owed result, then let the pipeline settle
	task drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task write_threshold(logic [THR_BITS-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.threshold = value;
	endtask

	// Time values shaped by mode: full range, near-equal, tiny, or extreme
	function logic [TIME_BITS-1:0] pick_time(int mode, logic [TIME_BITS-1:0] base);
		case (mode)
			0: return TIME_BITS'($urandom);
			1: return base + TIME_BITS'($urandom_range(0, 255));
			2: return TIME_BITS'($urandom_range(0, 3));
			default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
		endcase
	endfunction

	task random_items(int count, int mode);
		logic [TIME_BITS-1:0] base;
		int                   roll;
		logic [IDX_BITS-1:0]  idx;
		base = TIME_BITS'($urandom_range(4096, 1 << 22));
		for (int k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if ($urandom_range(0, 3) == 0)
				idx = IDX_BITS'($urandom);
			else
				idx = IDX_BITS'($urandom_range(0, (sb.held < MAX_STAGES) ? sb.held : 15));
			if (roll < 62)
				send_item(CMD_RECORD, idx, pick_time(mode, base));
			else if (roll < 92)
				send_item(CMD_READ, idx, TIME_BITS'($urandom));
			else if (roll < 96)
				send_item(CMD_CLEAR, idx, TIME_BITS'($urandom));
			else
				send_item(CMD_UNUSED, idx, TIME_BITS'($urandom));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = CMD_RECORD;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		idle_off = 1'b0;
		hold_request = 1'b0;
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, skipped stages, zero sums, extremes, clear
		send_item(CMD_READ, 4'd0, '0);
		send_item(CMD_RECORD, 4'd0, '1);
		send_item(CMD_READ, 4'd0, '0);
		send_item(CMD_RECORD, 4'd15, '0);
		send_item(CMD_READ, 4'd7, '0);
		send_item(CMD_READ, 4'd15, '1);
		send_item(CMD_UNUSED, 4'd3, '1);
		send_item(CMD_CLEAR, 4'd0, '0);
		send_item(CMD_READ, 4'd5, '0);
		send_item(CMD_RECORD, 4'd0, '0);
		send_item(CMD_RECORD, 4'd2, '0);
		send_item(CMD_RECORD, 4'd1, 24'h000001);
		send_item(CMD_RECORD, 4'd0, 24'h800000);
		send_item(CMD_RECORD, 4'd2, 24'h7FFFFF);
		send_item(CMD_CLEAR, 4'd9, '1);
		for (int i = 0; i < 4; i++) send_item(CMD_RECORD, IDX_BITS'(i), 24'h123456);
		send_item(CMD_RECORD, 4'd4, 24'h123457);
		send_item(CMD_READ, 4'd4, '0);
		send_item(CMD_CLEAR, 4'd0, '0);

		// Default threshold: mixed content, then a stretch with no idling
		random_items(300, 0);
		idle_off = 1'b1;
		random_items(150, 1);
		idle_off = 1'b0;

		// Hold off the receiver while the sender keeps offering
		hold_request = 1'b1;
		random_items(100, 1);

		write_threshold('0);
		random_items(350, 3);
		write_threshold('1);
		random_items(350, 2);
		write_threshold(THR_BITS'($urandom));
		random_items(350, 0);
		write_threshold(THR_BITS'($urandom_range(256, 4096)));
		random_items(400, 1);
		drain();

		$display("%0d transactions sent, %0d results checked, %0d balanced, %0d saturated",
			sent, sb.checked, sb.balanced_seen, sb.saturated_seen);
		$display("thresholds covered: reset, zero, full scale and random");
		if (sb.mismatches == 0 && sb.owed.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/stbm_pkg.sv
hw/rtl/stbm_ctrl.sv
hw/rtl/stbm_dp.sv
hw/rtl/stage_time_balance_monitor.sv
verif/stage_time_balance_monitor_tb.sv
